// ===== rtl/btcs_pkg.sv =====
// shared constants and helpers for the bracket tape step machine
package btcs_pkg;

    // default store depths
    localparam int unsigned PROG_DEPTH_DEF = 4096;
    localparam int unsigned TAPE_DEPTH_DEF = 4096;

    // fixed field widths
    localparam int unsigned ADDR_W = 12;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STAT_W = 3;

    // shift used by the reciprocal that folds a load address into the store
    localparam int unsigned RECIP_SHIFT = 24;

    // opcode characters
    localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E; // '>'
    localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C; // '<'
    localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B; // '+'
    localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D; // '-'
    localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E; // '.'
    localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C; // ','
    localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B; // '['
    localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D; // ']'

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_OP    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SCAN  = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNMATCHED = 3'd3;
    localparam logic [STAT_W-1:0] ST_HALTED    = 3'd4;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    function automatic logic is_plain(input logic [BYTE_W-1:0] c);
        return (c == OP_RIGHT) || (c == OP_LEFT) || (c == OP_INC) ||
               (c == OP_DEC) || (c == OP_OUT) || (c == OP_IN);
    endfunction

endpackage

// ===== rtl/bracket_tape_cpu_step.sv =====
// top level of the bracket tape step machine: program store, data tape and sequencer
//
// A byte-tape machine: load requests write one opcode byte into the program store, step
// requests execute the opcode at the instruction pointer against the data tape. Both stores
// are synchronous memories with a registered read port; one request is in
// work at a time and a finished result sits in an output register, so the next request is
// taken while that result waits. A load folds its address by reciprocal, then writes the
// store. A plain step reads program and tape, then executes with the tape write-back; a step
// while halted goes straight to its result. A bracket that jumps scans the program bytes
// one byte per cycle through the program store read port before its result. After reset
// both stores are swept to zero, one entry per cycle over max(PROG_DEPTH, TAPE_DEPTH)
// entries, and no request is taken until the sweep ends.
module bracket_tape_cpu_step #(
    parameter int unsigned PROG_DEPTH = btcs_pkg::PROG_DEPTH_DEF,
    parameter int unsigned TAPE_DEPTH = btcs_pkg::TAPE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           req_type,
    input  logic [btcs_pkg::ADDR_W-1:0]    load_addr,
    input  logic [btcs_pkg::BYTE_W-1:0]    load_byte,
    input  logic [btcs_pkg::BYTE_W-1:0]    in_byte,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [btcs_pkg::STAT_W-1:0]    status,
    output logic                           out_valid,
    output logic [btcs_pkg::BYTE_W-1:0]    out_byte,
    output logic [btcs_pkg::ADDR_W-1:0]    instr_ptr,
    output logic [btcs_pkg::ADDR_W-1:0]    data_ptr
);

    localparam int unsigned PW        = $clog2(PROG_DEPTH);
    localparam int unsigned TW        = $clog2(TAPE_DEPTH);
    localparam int unsigned MAX_DEPTH = (PROG_DEPTH > TAPE_DEPTH) ? PROG_DEPTH : TAPE_DEPTH;
    localparam int unsigned CW        = $clog2(MAX_DEPTH);
    localparam int unsigned AW        = btcs_pkg::ADDR_W;
    localparam int unsigned BW        = btcs_pkg::BYTE_W;
    localparam int unsigned SW        = btcs_pkg::STAT_W;
    localparam int unsigned PRECIP    = (1 << btcs_pkg::RECIP_SHIFT) / PROG_DEPTH;
    localparam int unsigned PRODW     = AW + btcs_pkg::RECIP_SHIFT;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LQUOT  = 7'b0000100,
        S_LWRITE = 7'b0001000,
        S_EXEC   = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    // memories
    logic [BW-1:0] prog_mem [PROG_DEPTH];
    logic [BW-1:0] tape_mem [TAPE_DEPTH];

    logic          prog_we, prog_re, tape_we, tape_re;
    logic [PW-1:0] prog_waddr, prog_raddr;
    logic [TW-1:0] tape_waddr, tape_raddr;
    logic [BW-1:0] prog_wdata, tape_wdata;
    logic [BW-1:0] prog_rdata_reg, tape_rdata_reg;

    // control and working registers
    state_t        state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0] ip_reg, ip_next;
    logic [TW-1:0] dp_reg, dp_next;
    logic          halted_reg, halted_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [BW-1:0] byte_reg, byte_next;
    logic [AW-1:0] quot_reg, quot_next;
    logic          dir_reg, dir_next;
    logic [PW-1:0] chk_reg, chk_next;
    logic [PW:0]   depth_reg, depth_next;
    logic [SW-1:0] res_status_reg, res_status_next;

    // output register
    logic          vld_reg, vld_next;
    logic [SW-1:0] status_reg, status_next;
    logic          outv_reg, outv_next;
    logic [BW-1:0] outb_reg, outb_next;
    logic [AW-1:0] iptr_reg, iptr_next;
    logic [AW-1:0] dptr_reg, dptr_next;

    // combinational helpers
    logic             out_free, req_fire, emit;
    logic [SW-1:0]    st;
    logic             ov;
    logic [BW-1:0]    ob;
    logic [PW-1:0]    ip_inc;
    logic [TW-1:0]    dp_inc, dp_dec;
    logic [BW-1:0]    op, cur_cell;
    logic [PRODW-1:0] prod;
    logic [31:0]      rem;
    logic [PW:0]      depth_new;
    logic             is_open, is_close, scan_bad, scan_at_edge;
    logic [PW+AW-1:0] ip_wide;
    logic [TW+AW-1:0] dp_wide;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign out_free  = !vld_reg || !rsp_stall;

    assign rsp_valid = vld_reg;
    assign status    = status_reg;
    assign out_valid = outv_reg;
    assign out_byte  = outb_reg;
    assign instr_ptr = iptr_reg;
    assign data_ptr  = dptr_reg;

    assign ip_inc = (ip_reg == PW'(PROG_DEPTH - 1)) ? '0 : ip_reg + 1'b1;
    assign dp_inc = (dp_reg == TW'(TAPE_DEPTH - 1)) ? '0 : dp_reg + 1'b1;
    assign dp_dec = (dp_reg == '0) ? TW'(TAPE_DEPTH - 1) : dp_reg - 1'b1;

    assign op       = prog_rdata_reg;
    assign cur_cell = tape_rdata_reg;

    // nesting count update for the byte under scan
    always_comb
    begin
        is_open   = (op == btcs_pkg::OP_OPEN);
        is_close  = (op == btcs_pkg::OP_CLOSE);
        scan_bad  = !(is_open || is_close || btcs_pkg::is_plain(op));
        depth_new = depth_reg;
        if ((dir_reg && is_close) || (!dir_reg && is_open))
        begin
            depth_new = depth_reg - 1'b1;
        end
        else if ((dir_reg && is_open) || (!dir_reg && is_close))
        begin
            depth_new = depth_reg + 1'b1;
        end
        scan_at_edge = dir_reg ? (chk_reg == PW'(PROG_DEPTH - 1)) : (chk_reg == '0);
    end

    // load address folded into the store: quotient estimate is low by at most one
    assign prod = PRODW'(addr_reg) * PRODW'(PRECIP);
    always_comb
    begin
        rem = 32'(addr_reg) - 32'(quot_reg) * 32'(PROG_DEPTH);
        if (rem >= 32'(PROG_DEPTH))
        begin
            rem = rem - 32'(PROG_DEPTH);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        ip_next         = ip_reg;
        dp_next         = dp_reg;
        halted_next     = halted_reg;
        addr_next       = addr_reg;
        byte_next       = byte_reg;
        quot_next       = quot_reg;
        dir_next        = dir_reg;
        chk_next        = chk_reg;
        depth_next      = depth_reg;
        res_status_next = res_status_reg;

        vld_next    = rsp_stall ? vld_reg : 1'b0;
        status_next = status_reg;
        outv_next   = outv_reg;
        outb_next   = outb_reg;
        iptr_next   = iptr_reg;
        dptr_next   = dptr_reg;

        prog_we    = 1'b0;
        prog_waddr = ip_reg;
        prog_wdata = '0;
        prog_re    = 1'b0;
        prog_raddr = ip_reg;
        tape_we    = 1'b0;
        tape_waddr = dp_reg;
        tape_wdata = '0;
        tape_re    = 1'b0;
        tape_raddr = dp_reg;

        emit = 1'b0;
        st   = btcs_pkg::ST_OK;
        ov   = 1'b0;
        ob   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                if ({1'b0, clr_cnt_reg} < (CW + 1)'(PROG_DEPTH))
                begin
                    prog_we    = 1'b1;
                    prog_waddr = clr_cnt_reg[PW-1:0];
                end
                if ({1'b0, clr_cnt_reg} < (CW + 1)'(TAPE_DEPTH))
                begin
                    tape_we    = 1'b1;
                    tape_waddr = clr_cnt_reg[TW-1:0];
                end
                if (clr_cnt_reg == CW'(MAX_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    addr_next = load_addr;
                    byte_next = (req_type == btcs_pkg::REQ_STEP) ? in_byte : load_byte;
                    if (req_type == btcs_pkg::REQ_LOAD)
                    begin
                        state_next = S_LQUOT;
                    end
                    else if (halted_reg)
                    begin
                        res_status_next = btcs_pkg::ST_HALTED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        prog_re    = 1'b1;
                        tape_re    = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end

            S_LQUOT:
            begin
                quot_next  = prod[PRODW-1 -: AW];
                state_next = S_LWRITE;
            end

            S_LWRITE:
            begin
                if (out_free)
                begin
                    prog_we    = 1'b1;
                    prog_waddr = rem[PW-1:0];
                    prog_wdata = byte_reg;
                    emit       = 1'b1;
                    st         = halted_reg ? btcs_pkg::ST_HALTED : btcs_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end

            S_EXEC:
            begin
                if ((op == btcs_pkg::OP_OPEN) && (cur_cell == '0))
                begin
                    if (ip_reg == PW'(PROG_DEPTH - 1))
                    begin
                        res_status_next = btcs_pkg::ST_UNMATCHED;
                        halted_next     = 1'b1;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        prog_re    = 1'b1;
                        prog_raddr = ip_reg + 1'b1;
                        chk_next   = ip_reg + 1'b1;
                        depth_next = (PW + 1)'(1);
                        dir_next   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else if ((op == btcs_pkg::OP_CLOSE) && (cur_cell != '0))
                begin
                    if (ip_reg == '0)
                    begin
                        res_status_next = btcs_pkg::ST_UNMATCHED;
                        halted_next     = 1'b1;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        prog_re    = 1'b1;
                        prog_raddr = ip_reg - 1'b1;
                        chk_next   = ip_reg - 1'b1;
                        depth_next = (PW + 1)'(1);
                        dir_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    ip_next    = ip_inc;
                    state_next = S_IDLE;
                    case (op)
                        btcs_pkg::OP_RIGHT: dp_next = dp_inc;
                        btcs_pkg::OP_LEFT:  dp_next = dp_dec;
                        btcs_pkg::OP_INC:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = cur_cell + 1'b1;
                        end
                        btcs_pkg::OP_DEC:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = cur_cell - 1'b1;
                        end
                        btcs_pkg::OP_OUT:
                        begin
                            ov = 1'b1;
                            ob = cur_cell;
                        end
                        btcs_pkg::OP_IN:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = byte_reg;
                        end
                        btcs_pkg::OP_OPEN, btcs_pkg::OP_CLOSE:
                        begin
                            // bracket that falls through
                        end
                        default:
                        begin
                            st      = btcs_pkg::ST_BAD_OP;
                            ip_next = ip_reg;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (scan_bad)
                begin
                    res_status_next = btcs_pkg::ST_BAD_SCAN;
                    halted_next     = 1'b1;
                    state_next      = S_DONE;
                end
                else if (depth_new == '0)
                begin
                    // jump lands just past the partner bracket
                    ip_next = (dir_reg && scan_at_edge) ? '0 : chk_reg + 1'b1;
                    res_status_next = btcs_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else if (scan_at_edge)
                begin
                    res_status_next = btcs_pkg::ST_UNMATCHED;
                    halted_next     = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    prog_re    = 1'b1;
                    prog_raddr = dir_reg ? chk_reg + 1'b1 : chk_reg - 1'b1;
                    chk_next   = prog_raddr;
                    depth_next = depth_new;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    st         = res_status_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ip_wide = {{AW{1'b0}}, ip_next};
        dp_wide = {{AW{1'b0}}, dp_next};
        if (emit)
        begin
            vld_next    = 1'b1;
            status_next = st;
            outv_next   = ov;
            outb_next   = ob;
            iptr_next   = ip_wide[AW-1:0];
            dptr_next   = dp_wide[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            ip_reg      <= '0;
            dp_reg      <= '0;
            halted_reg  <= 1'b0;
            vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ip_reg      <= ip_next;
            dp_reg      <= dp_next;
            halted_reg  <= halted_next;
            vld_reg     <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        byte_reg       <= byte_next;
        quot_reg       <= quot_next;
        dir_reg        <= dir_next;
        chk_reg        <= chk_next;
        depth_reg      <= depth_next;
        res_status_reg <= res_status_next;
        status_reg     <= status_next;
        outv_reg       <= outv_next;
        outb_reg       <= outb_next;
        iptr_reg       <= iptr_next;
        dptr_reg       <= dptr_next;
    end

    // program store
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_waddr] <= prog_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prog_re)
        begin
            prog_rdata_reg <= prog_mem[prog_raddr];
        end
    end

    // data tape
    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tape_re)
        begin
            tape_rdata_reg <= tape_mem[tape_raddr];
        end
    end

`ifndef SYNTHESIS
    // only reset releases a halt
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    // an emitted byte only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_valid) |-> (status == btcs_pkg::ST_OK))
        else $error("emitted byte with error status");

    // no emitted byte means a zero byte field
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !out_valid) |-> (out_byte == '0))
        else $error("byte field set without emit");

    // tape is only written by the sweep or by executing an opcode
    assert property (@(posedge clk) disable iff (!rst_n)
        tape_we |-> ((state_reg == S_EXEC) || (state_reg == S_CLEAR)))
        else $error("tape written outside execute or sweep");

    // a scan never starts while halted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !$past(halted_reg))
        else $error("scan while halted");
`endif

endmodule
